>>> rtl/core/lfu_frame_replacement_top_defines.svh
// Assertion macros for the LFU replacement table checker.
// Used by lfr_checker.sv; no other dependencies.
`ifndef LFU_FRAME_REPLACEMENT_TOP_DEFINES_SVH
`define LFU_FRAME_REPLACEMENT_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and reset.
`define LFR_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define LFR_ASSERT(lbl, prop, msg) `LFR_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

>>> rtl/core/lfr_pkg.sv
// Shared types and constants for the LFU replacement table.
// No dependencies; imported by lfr_scan and the top level.
package lfr_pkg;

   localparam int COUNT_W = 16;
   localparam int AGE_W   = 32;
   localparam int CAP_W   = 5;
   localparam int CMP_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_LIST   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } lfr_state_type;

   // Outcome flags of one pass over the table
   typedef struct packed {
      logic match;
      logic free;
      logic victim;
      logic pick;
   } scan_flags_type;

endpackage

>>> rtl/core/lfr_store.sv
// Entry memory (key, count, age) with one read and one write port,
// plus per-entry valid flops. Depends on nothing but its parameters.
module lfr_store #(
   parameter int ENTRIES = 16,
   parameter int AW      = 4,
   parameter int EW      = 56
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   output logic          rd_vld,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data
);

   logic [EW-1:0]      mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [EW-1:0]      rd_data_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_vld  = rd_vld_ff;

endmodule

>>> rtl/core/lfr_scan.sv
// Shared compare unit: takes one entry per cycle while en is high and
// accumulates match, first free slot, LFU victim, held count and next
// key for read out. Depends on lfr_pkg.
module lfr_scan #(
   parameter int KEY_WIDTH = 8,
   parameter int AW        = 4,
   parameter int HW        = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clr,
   input  logic                          en,
   input  logic                          list_mode,
   input  logic                          have_prev,
   input  logic [KEY_WIDTH-1:0]          prev_key,
   input  logic [KEY_WIDTH-1:0]          probe_key,
   input  logic [AW-1:0]                 idx,
   input  logic                          ent_vld,
   input  logic [KEY_WIDTH-1:0]          ent_key,
   input  logic [lfr_pkg::COUNT_W-1:0]   ent_count,
   input  logic [lfr_pkg::AGE_W-1:0]     ent_age,
   output lfr_pkg::scan_flags_type       flags,
   output logic [HW-1:0]                 held,
   output logic [AW-1:0]                 match_idx,
   output logic [lfr_pkg::COUNT_W-1:0]   match_count,
   output logic [lfr_pkg::AGE_W-1:0]     match_age,
   output logic [AW-1:0]                 free_idx,
   output logic [AW-1:0]                 victim_idx,
   output logic [KEY_WIDTH-1:0]          victim_key,
   output logic [KEY_WIDTH-1:0]          pick_key,
   output logic [lfr_pkg::COUNT_W-1:0]   pick_count
);
   import lfr_pkg::*;

   scan_flags_type       flags_ff, flags_in;
   logic [HW-1:0]        held_ff, held_in;
   logic [AW-1:0]        match_idx_ff, match_idx_in;
   logic [COUNT_W-1:0]   match_count_ff, match_count_in;
   logic [AGE_W-1:0]     match_age_ff, match_age_in;
   logic [AW-1:0]        free_idx_ff, free_idx_in;
   logic [AW-1:0]        victim_idx_ff, victim_idx_in;
   logic [KEY_WIDTH-1:0] victim_key_ff, victim_key_in;
   logic [COUNT_W-1:0]   victim_count_ff, victim_count_in;
   logic [AGE_W-1:0]     victim_age_ff, victim_age_in;
   logic [KEY_WIDTH-1:0] pick_key_ff, pick_key_in;
   logic [COUNT_W-1:0]   pick_count_ff, pick_count_in;
   logic                 lower;
   logic                 above_prev;

   always_comb begin
      flags_in        = flags_ff;
      held_in         = held_ff;
      match_idx_in    = match_idx_ff;
      match_count_in  = match_count_ff;
      match_age_in    = match_age_ff;
      free_idx_in     = free_idx_ff;
      victim_idx_in   = victim_idx_ff;
      victim_key_in   = victim_key_ff;
      victim_count_in = victim_count_ff;
      victim_age_in   = victim_age_ff;
      pick_key_in     = pick_key_ff;
      pick_count_in   = pick_count_ff;

      // lowest count wins, oldest insert breaks a tie
      lower = !flags_ff.victim || (ent_count < victim_count_ff) ||
              ((ent_count == victim_count_ff) && (ent_age < victim_age_ff));
      above_prev = !have_prev || (ent_key > prev_key);

      if (clr) begin
         flags_in = '0;
         held_in  = '0;
      end else if (en) begin
         if (!ent_vld) begin
            if (!flags_ff.free) begin
               flags_in.free = 1'b1;
               free_idx_in   = idx;
            end
         end else begin
            held_in = held_ff + HW'(1);
            if (list_mode) begin
               if (above_prev && (!flags_ff.pick || (ent_key < pick_key_ff))) begin
                  flags_in.pick = 1'b1;
                  pick_key_in   = ent_key;
                  pick_count_in = ent_count;
               end
            end else begin
               if (ent_key == probe_key) begin
                  flags_in.match = 1'b1;
                  match_idx_in   = idx;
                  match_count_in = ent_count;
                  match_age_in   = ent_age;
               end
               if (lower) begin
                  flags_in.victim = 1'b1;
                  victim_idx_in   = idx;
                  victim_key_in   = ent_key;
                  victim_count_in = ent_count;
                  victim_age_in   = ent_age;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         held_ff  <= '0;
      end else begin
         flags_ff <= flags_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff    <= match_idx_in;
      match_count_ff  <= match_count_in;
      match_age_ff    <= match_age_in;
      free_idx_ff     <= free_idx_in;
      victim_idx_ff   <= victim_idx_in;
      victim_key_ff   <= victim_key_in;
      victim_count_ff <= victim_count_in;
      victim_age_ff   <= victim_age_in;
      pick_key_ff     <= pick_key_in;
      pick_count_ff   <= pick_count_in;
   end

   assign flags       = flags_ff;
   assign held        = held_ff;
   assign match_idx   = match_idx_ff;
   assign match_count = match_count_ff;
   assign match_age   = match_age_ff;
   assign free_idx    = free_idx_ff;
   assign victim_idx  = victim_idx_ff;
   assign victim_key  = victim_key_ff;
   assign pick_key    = pick_key_ff;
   assign pick_count  = pick_count_ff;

endmodule

>>> rtl/core/lfu_frame_replacement_top.sv
// Top level of the LFU replacement table: sequencer, output register,
// capacity register. Depends on lfr_pkg, lfr_store and lfr_scan.
//
// Usage:
//   req_*  : one item per access (req_tuser = 0, key in req_tdata) or
//            read-out request (req_tuser = 1). Taken only while idle.
//   rsp_*  : an access gives one item; a read out gives one item per held
//            entry in ascending key order (one item if empty); tlast marks
//            the final item of a request.
//   csr_*  : capacity write, always ready; write only while idle.
// Timing: every request sweeps the entry memory through one compare unit,
//   one entry per cycle on a single read port with registered data.
//   An access completes before the next request is taken; a read out
//   makes one full sweep per listed entry.
// Reset: table empty, capacity 16, sequence zero; no clearing pass.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and the sequencer holds before loading another result.
module lfu_frame_replacement_top #(
   parameter int ENTRIES   = 16,
   parameter int KEY_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_tuser,  // op
   input  logic [((KEY_WIDTH+7)/8)*8-1:0]         req_tdata,  // key
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [2:0]                             rsp_tuser,  // hit, evicted_valid,
                                                              // listed_valid
   output logic [((2*KEY_WIDTH+16+7)/8)*8-1:0]    rsp_tdata,  // evicted_key,
                                                              // listed_key, listed_count
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lfr_pkg::CAP_W-1:0]              csr_data    // capacity
);
   import lfr_pkg::*;

   localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int HW     = $clog2(ENTRIES + 1);
   localparam int EW     = KEY_WIDTH + COUNT_W + AGE_W;
   localparam int RSP_DW = ((2*KEY_WIDTH+16+7)/8)*8;

   lfr_state_type        state_ff, state_in;
   logic                 op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pidx_ff, pidx_in;
   logic                 have_prev_ff, have_prev_in;
   logic [KEY_WIDTH-1:0] prev_key_ff, prev_key_in;
   logic [HW-1:0]        list_num_ff, list_num_in;
   logic [AGE_W-1:0]     seq_ff, seq_in;
   logic [CAP_W-1:0]     cap_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_user_ff, rsp_user_in;
   logic [RSP_DW-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [EW-1:0]        rd_data;
   logic                 rd_vld;
   logic                 scan_clr;
   logic                 out_free;
   logic                 list_last;
   logic [CMP_W-1:0]     cap_eff;
   logic [COUNT_W-1:0]   hit_count;

   scan_flags_type       flags;
   logic [HW-1:0]        held;
   logic [AW-1:0]        match_idx;
   logic [COUNT_W-1:0]   match_count;
   logic [AGE_W-1:0]     match_age;
   logic [AW-1:0]        free_idx;
   logic [AW-1:0]        victim_idx;
   logic [KEY_WIDTH-1:0] victim_key;
   logic [KEY_WIDTH-1:0] pick_key;
   logic [COUNT_W-1:0]   pick_count;

   // memory word layout: {age, count, key}
   lfr_store #(.ENTRIES(ENTRIES), .AW(AW), .EW(EW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (addr_ff),
      .rd_data (rd_data),
      .rd_vld  (rd_vld),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lfr_scan #(.KEY_WIDTH(KEY_WIDTH), .AW(AW), .HW(HW)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clr         (scan_clr),
      .en          (pend_ff),
      .list_mode   (op_ff),
      .have_prev   (have_prev_ff),
      .prev_key    (prev_key_ff),
      .probe_key   (key_ff),
      .idx         (pidx_ff),
      .ent_vld     (rd_vld),
      .ent_key     (rd_data[KEY_WIDTH-1:0]),
      .ent_count   (rd_data[KEY_WIDTH +: COUNT_W]),
      .ent_age     (rd_data[KEY_WIDTH+COUNT_W +: AGE_W]),
      .flags       (flags),
      .held        (held),
      .match_idx   (match_idx),
      .match_count (match_count),
      .match_age   (match_age),
      .free_idx    (free_idx),
      .victim_idx  (victim_idx),
      .victim_key  (victim_key),
      .pick_key    (pick_key),
      .pick_count  (pick_count)
   );

   // capacity 0 acts as 1, above the built size as the built size
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   assign hit_count = (match_count == COUNT_MAX) ? match_count : match_count + COUNT_W'(1);
   assign list_last = (list_num_ff + HW'(1)) == held;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      have_prev_in = have_prev_ff;
      prev_key_in  = prev_key_ff;
      list_num_in  = list_num_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = match_idx;
      wr_data      = {match_age, hit_count, key_ff};
      scan_clr     = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               key_in       = req_tdata[KEY_WIDTH-1:0];
               addr_in      = '0;
               have_prev_in = 1'b0;
               list_num_in  = '0;
               scan_clr     = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b1;
            pidx_in = addr_ff;
            if (addr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 3'b000;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_ACCESS) begin
                  seq_in = seq_ff + AGE_W'(1);
                  if (flags.match) begin
                     wr_en          = 1'b1;
                     rsp_user_in[0] = 1'b1;
                  end else if ((CMP_W'(held) < cap_eff) && flags.free) begin
                     wr_en   = 1'b1;
                     wr_addr = free_idx;
                     wr_data = {seq_ff, COUNT_W'(1), key_ff};
                  end else if (flags.victim) begin
                     wr_en          = 1'b1;
                     wr_addr        = victim_idx;
                     wr_data        = {seq_ff, COUNT_W'(1), key_ff};
                     rsp_user_in[1] = 1'b1;
                     rsp_data_in    = RSP_DW'(victim_key);
                  end
               end else if (flags.pick) begin
                  rsp_user_in[2] = 1'b1;
                  rsp_data_in    = RSP_DW'({pick_count, pick_key, KEY_WIDTH'(0)});
                  rsp_last_in    = list_last;
                  prev_key_in    = pick_key;
                  have_prev_in   = 1'b1;
                  list_num_in    = list_num_ff + HW'(1);
                  if (!list_last) begin
                     scan_clr = 1'b1;
                     addr_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ACCESS;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         list_num_ff  <= '0;
         seq_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         have_prev_ff <= have_prev_in;
         list_num_ff  <= list_num_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      pidx_ff     <= pidx_in;
      prev_key_ff <= prev_key_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/core/lfr_checker.sv
// Port-level checks for the LFU replacement table, bound to the top level.
// Depends on lfu_frame_replacement_top_defines.svh.
`include "lfu_frame_replacement_top_defines.svh"

module lfr_checker #(
   parameter int KEY_WIDTH = 8
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [2:0]                          rsp_tuser,
   input logic [((2*KEY_WIDTH+16+7)/8)*8-1:0] rsp_tdata,
   input logic                                rsp_tlast
);

   // a stalled result keeps its payload
   `LFR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")

   // the table sweep keeps the block busy after taking a request
   `LFR_ASSERT(a_busy_after_req, req_tvalid && req_tready |=> !req_tready, "request taken back to back")

   // access results are single items: hit and eviction close the request
   `LFR_ASSERT(a_access_last, rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tlast, "access item without last")

   // an item is either an access result or a listed entry, and a hit never evicts
   `LFR_ASSERT(a_kind_excl, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) && !(rsp_tuser[2] && (rsp_tuser[0] || rsp_tuser[1])), "conflicting result flags")

endmodule

bind lfu_frame_replacement_top lfr_checker #(.KEY_WIDTH(KEY_WIDTH)) u_lfr_checker (.*);
